@@ hdl/ipv6_text_address_parser_assert.svh @@
// Assertion macros used by the checker.
`ifndef IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IP6TAP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ip6tap: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IP6TAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ip6tap: next-cycle check failed");

`endif

@@ hdl/ip6tap_pkg.sv @@
package ip6tap_pkg;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_LEAD  = 2'd1,
        PH_HEX   = 2'd2,
        PH_TAIL  = 2'd3
    } phase_t;

    typedef logic [7:0][15:0] group_set_t;

    typedef struct packed {
        logic [3:0]  gw;
        logic [3:0]  gap_index;
        logic        gap_seen;
        logic [15:0] hex;
        logic        saw_hex;
        phase_t      phase;
        logic [7:0]  octet;
        logic [1:0]  digits;
        logic        tdok;
        logic [1:0]  dots;
        logic [23:0] tail;
        logic        err;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        gw:        4'd0,
        gap_index: 4'd0,
        gap_seen:  1'b0,
        hex:       16'd0,
        saw_hex:   1'b0,
        phase:     PH_START,
        octet:     8'd0,
        digits:    2'd0,
        tdok:      1'b1,
        dots:      2'd0,
        tail:      24'd0,
        err:       1'b0
    };

endpackage

@@ hdl/ip6tap_char_if.sv @@
interface ip6tap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ hdl/ip6tap_addr_if.sv @@
interface ip6tap_addr_if;
    logic        valid;
    logic        ready;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        status;

    modport source (output valid, output addr_high, output addr_low, output status, input ready);
    modport sink   (input valid, input addr_high, input addr_low, input status, output ready);
endinterface

@@ hdl/ipv6_text_address_parser.sv @@
// IPv6 text address parser. One ASCII character per request on text, with last set
// on the final character; for each address one result leaves on result: the
// 128-bit address (addr_high holds bytes 0-7) with any "::" gap zero-filled,
// and status 1 for malformed text, in which case the address reads zero. A
// dotted IPv4 tail is accepted for the low 32 bits. The block takes one
// character every cycle unless a last character waits behind an untaken result;
// the result passes the input register and then the result register, around the
// combinational character update and gap expansion. Characters keep flowing while
// a result waits; only a further last character stalls until the result is taken.
module ipv6_text_address_parser (
    input  logic          clk,
    input  logic          rst_n,
    ip6tap_char_if.sink   text,
    ip6tap_addr_if.source result
);
    import ip6tap_pkg::*;

    logic         s1_valid_reg;
    logic [7:0]   ch_reg;
    logic         last_reg;
    parse_state_t st_reg;
    parse_state_t st_next;
    group_set_t   words_reg;
    group_set_t   words_next;
    logic         out_valid_reg;
    logic [63:0]  out_high_reg;
    logic [63:0]  out_low_reg;
    logic         out_status_reg;
    logic [63:0]  fin_high;
    logic [63:0]  fin_low;
    logic         fin_status;
    logic         stall;
    logic         s1_go;

    ip6tap_step u_step (
        .st         (st_reg),
        .words      (words_reg),
        .ch         (ch_reg),
        .last       (last_reg),
        .st_next    (st_next),
        .words_next (words_next)
    );

    ip6tap_finish u_finish (
        .st        (st_next),
        .words     (words_next),
        .addr_high (fin_high),
        .addr_low  (fin_low),
        .status    (fin_status)
    );

    assign stall        = out_valid_reg && !result.ready;
    assign s1_go        = s1_valid_reg && (!last_reg || !stall);
    assign text.ready   = !s1_valid_reg || s1_go;

    assign result.valid     = out_valid_reg;
    assign result.addr_high = out_high_reg;
    assign result.addr_low  = out_low_reg;
    assign result.status    = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            st_reg        <= PARSE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (text.ready)
                s1_valid_reg <= text.valid;
            if (s1_go)
                st_reg <= last_reg ? PARSE_RESET : st_next;
            if (s1_go && last_reg)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            ch_reg   <= text.ch;
            last_reg <= text.last;
        end
        if (s1_go)
            words_reg <= words_next;
        if (s1_go && last_reg)
        begin
            out_high_reg   <= fin_high;
            out_low_reg    <= fin_low;
            out_status_reg <= fin_status;
        end
    end

endmodule

@@ hdl/ip6tap_step.sv @@
// Per-character state update.
module ip6tap_step (
    input  ip6tap_pkg::parse_state_t st,
    input  ip6tap_pkg::group_set_t   words,
    input  logic [7:0]               ch,
    input  logic                     last,
    output ip6tap_pkg::parse_state_t st_next,
    output ip6tap_pkg::group_set_t   words_next
);
    import ip6tap_pkg::*;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    logic        is_digit;
    logic        is_hex;
    logic        is_colon;
    logic        is_dot;
    logic [3:0]  hv;
    logic [11:0] dec_sum;
    logic        dec_ok;
    logic        grp;
    logic        ok;

    always_comb
    begin
        is_digit = (ch >= CH_0) && (ch <= CH_9);
        is_hex   = is_digit || ((ch >= CH_UA) && (ch <= CH_UF))
                   || ((ch >= CH_LA) && (ch <= CH_LF));
        is_colon = (ch == CH_COLON);
        is_dot   = (ch == CH_DOT);
        hv       = is_digit ? ch[3:0] : ch[3:0] + 4'd9;
        dec_sum  = ({4'd0, st.octet} << 3) + ({4'd0, st.octet} << 1) + {8'd0, ch[3:0]};
        dec_ok   = !((st.digits != 2'd0) && (st.octet == 8'd0)) && (dec_sum <= 12'd255);
    end

    always_comb
    begin
        st_next    = st;
        words_next = words;
        ok         = 1'b1;
        grp        = 1'b0;

        if (!st.err)
        begin
            case (st.phase)
                PH_START:
                begin
                    if (is_colon)
                    begin
                        if (last)
                            ok = 1'b0;
                        else
                            st_next.phase = PH_LEAD;
                    end
                    else
                    begin
                        st_next.phase = PH_HEX;
                        grp = 1'b1;
                    end
                end
                PH_LEAD:
                begin
                    if (!is_colon)
                        ok = 1'b0;
                    else
                    begin
                        st_next.phase = PH_HEX;
                        grp = 1'b1;
                    end
                end
                PH_HEX:
                    grp = 1'b1;
                PH_TAIL:
                begin
                    if (is_digit)
                    begin
                        if (!dec_ok)
                            ok = 1'b0;
                        else
                        begin
                            st_next.octet = dec_sum[7:0];
                            if (st.digits != 2'd3)
                                st_next.digits = st.digits + 2'd1;
                        end
                    end
                    else if (is_dot)
                    begin
                        if ((st.dots == 2'd3) || (st.digits == 2'd0))
                            ok = 1'b0;
                        else
                        begin
                            st_next.tail   = {st.tail[15:0], st.octet};
                            st_next.dots   = st.dots + 2'd1;
                            st_next.octet  = 8'd0;
                            st_next.digits = 2'd0;
                        end
                    end
                    else
                        ok = 1'b0;
                end
                default:
                    ok = 1'b0;
            endcase

            if (grp)
            begin
                if (is_hex)
                begin
                    if (st.hex[15:12] != 4'd0)
                        ok = 1'b0;
                    else
                    begin
                        st_next.hex     = {st.hex[11:0], hv};
                        st_next.saw_hex = 1'b1;
                        if (st.tdok)
                        begin
                            if (!is_digit || !dec_ok)
                                st_next.tdok = 1'b0;
                            else
                            begin
                                st_next.octet = dec_sum[7:0];
                                if (st.digits != 2'd3)
                                    st_next.digits = st.digits + 2'd1;
                            end
                        end
                    end
                end
                else if (is_colon)
                begin
                    st_next.octet  = 8'd0;
                    st_next.digits = 2'd0;
                    st_next.tdok   = 1'b1;
                    if (!st.saw_hex)
                    begin
                        if (st.gap_seen)
                            ok = 1'b0;
                        else
                        begin
                            st_next.gap_seen  = 1'b1;
                            st_next.gap_index = st.gw;
                        end
                    end
                    else if (last || (st.gw >= 4'd8))
                        ok = 1'b0;
                    else
                    begin
                        words_next[st.gw[2:0]] = st.hex;
                        st_next.gw      = st.gw + 4'd1;
                        st_next.hex     = 16'd0;
                        st_next.saw_hex = 1'b0;
                    end
                end
                else if (is_dot)
                begin
                    if ((st.gw > 4'd6) || !st.tdok || (st.digits == 2'd0))
                        ok = 1'b0;
                    else
                    begin
                        st_next.tail    = {16'd0, st.octet};
                        st_next.dots    = 2'd1;
                        st_next.octet   = 8'd0;
                        st_next.digits  = 2'd0;
                        st_next.hex     = 16'd0;
                        st_next.saw_hex = 1'b0;
                        st_next.phase   = PH_TAIL;
                    end
                end
                else
                    ok = 1'b0;
            end

            if (!ok)
                st_next.err = 1'b1;
        end
    end

endmodule

@@ hdl/ip6tap_finish.sv @@
// End-of-address checks, pending group write and gap expansion.
module ip6tap_finish (
    input  ip6tap_pkg::parse_state_t st,
    input  ip6tap_pkg::group_set_t   words,
    output logic [63:0]              addr_high,
    output logic [63:0]              addr_low,
    output logic                     status
);
    import ip6tap_pkg::*;

    group_set_t  g;
    group_set_t  w;
    logic [31:0] v4;
    logic [3:0]  gwf;
    logic [3:0]  n;
    logic        fail;

    always_comb
    begin
        g    = words;
        w    = '0;
        v4   = {st.tail, st.octet};
        gwf  = st.gw;
        fail = st.err;

        if (st.phase == PH_TAIL)
        begin
            if ((st.dots != 2'd3) || (st.digits == 2'd0) || (st.gw > 4'd6))
                fail = 1'b1;
            else
            begin
                g[st.gw[2:0]]        = v4[31:16];
                g[st.gw[2:0] + 3'd1] = v4[15:0];
                gwf = st.gw + 4'd2;
            end
        end
        else if (st.saw_hex)
        begin
            if (st.gw >= 4'd8)
                fail = 1'b1;
            else
            begin
                g[st.gw[2:0]] = st.hex;
                gwf = st.gw + 4'd1;
            end
        end

        n = gwf - st.gap_index;

        if (st.gap_seen)
        begin
            if ((gwf >= 4'd8) || (st.gap_index > gwf))
                fail = 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                if (4'(i) < st.gap_index)
                    w[i] = g[i];
                else if ((5'(i) + {1'b0, n}) >= 5'd8)
                    w[i] = g[3'(i) + gwf[2:0]];
                else
                    w[i] = 16'd0;
            end
        end
        else
        begin
            if (gwf != 4'd8)
                fail = 1'b1;
            w = g;
        end

        status    = fail;
        addr_high = fail ? 64'd0 : {w[0], w[1], w[2], w[3]};
        addr_low  = fail ? 64'd0 : {w[4], w[5], w[6], w[7]};
    end

endmodule

@@ hdl/ip6tap_checker.sv @@
`include "ipv6_text_address_parser_assert.svh"

module ip6tap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        text_valid,
    input logic        text_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [63:0] result_addr_high,
    input logic [63:0] result_addr_low,
    input logic        result_status
);

    // held result stays put
    `IP6TAP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_addr_high) && $stable(result_addr_low) && $stable(result_status))

    // rejected text reports an all-zero address
    `IP6TAP_ASSERT_IMPLY(a_bad_is_zero, result_valid && result_status, (result_addr_high == 64'd0) && (result_addr_low == 64'd0))

    // input only backs up behind a refused result
    `IP6TAP_ASSERT_IMPLY(a_backpressure_source, !text_ready, result_valid && !result_ready)

    // no request pending means nothing to refuse
    `IP6TAP_ASSERT_IMPLY(a_ready_idle, !text_valid && !result_valid, text_ready)

endmodule

bind ipv6_text_address_parser ip6tap_checker u_ip6tap_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_valid       (text.valid),
    .text_ready       (text.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_addr_high (result.addr_high),
    .result_addr_low  (result.addr_low),
    .result_status    (result.status)
);
